// ----- hdl/mkey_pkg.sv -----
// mkey_pkg: shared constants, register codes and pipeline types of the
// octree cell key core. No dependencies.

package mkey_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int MAX_LEVELS     = 10;
   localparam int NUM_AXES       = 3;
   localparam int KEY_WIDTH      = NUM_AXES * MAX_LEVELS;
   localparam int CELL_KEY_WIDTH = 30;
   localparam int DEPTH_WIDTH    = 4;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = COORD_WIDTH;

   localparam logic [COORD_WIDTH-1:0] BOX_MIN_RESET = COORD_WIDTH'(0);
   localparam logic [COORD_WIDTH-1:0] BOX_MAX_RESET = COORD_WIDTH'(65536);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_RESET   = DEPTH_WIDTH'(10);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_BOX_MIN_X  = 3'd0,
      CSR_BOX_MAX_X  = 3'd1,
      CSR_BOX_MIN_Y  = 3'd2,
      CSR_BOX_MAX_Y  = 3'd3,
      CSR_BOX_MIN_Z  = 3'd4,
      CSR_BOX_MAX_Z  = 3'd5,
      CSR_TREE_DEPTH = 3'd6
   } csr_index_type;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   // configuration as seen by the pipeline
   typedef struct packed {
      coord_type [NUM_AXES-1:0] box_min;
      coord_type [NUM_AXES-1:0] box_max;
      logic [DEPTH_WIDTH-1:0]   tree_depth;
   } cfg_type;

   // payload carried from one bisection stage to the next
   typedef struct packed {
      coord_type [NUM_AXES-1:0] point;
      coord_type [NUM_AXES-1:0] lo;
      coord_type [NUM_AXES-1:0] hi;
      logic [KEY_WIDTH-1:0]     key;
   } stage_type;

endpackage

// ----- hdl/octree_morton_key_core.sv -----
// octree_morton_key_core: top level of the octree cell key core.
// Depends on mkey_pkg, mkey_csr and mkey_level.
//
// Usage:
//  - req channel: one point (req_point_x/y/z, signed Q16.16) per item,
//    taken at a rising edge with req_valid high and req_stall low.
//  - rsp channel: one rsp_cell_key per point, in input order, taken at a
//    rising edge with rsp_valid high and rsp_stall low.
//  - csr port: csr_wr_en, csr_index and csr_wdata write the box bounds
//    (index 0..5) and tree_depth (index 6); other indexes are ignored.
//    Write only while no item is in flight.
//  - stages: one registered stage per bisection level; each stage does a
//    33-bit add and a 32-bit compare per axis.
//  - throughput: one item per cycle while req_stall is low.
//  - stall: a stalled result holds in the last stage; earlier stages keep
//    filling empty slots, so req_stall rises only when every stage is full
//    and the output is stalled.
//  - reset: synchronous, clears all stage valid bits and loads the box
//    [0, 1.0] on every axis with a depth of 10.

module octree_morton_key_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [mkey_pkg::COORD_WIDTH-1:0]        req_point_x,
   input  logic [mkey_pkg::COORD_WIDTH-1:0]        req_point_y,
   input  logic [mkey_pkg::COORD_WIDTH-1:0]        req_point_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mkey_pkg::CELL_KEY_WIDTH-1:0]     rsp_cell_key,
   input  logic                                    csr_wr_en,
   input  logic [mkey_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [mkey_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int L = mkey_pkg::MAX_LEVELS;

   mkey_pkg::cfg_type   cfg;
   mkey_pkg::stage_type entry_stage;
   mkey_pkg::stage_type st [L];
   logic [L-1:0]        st_valid;
   logic [L-1:0]        advance;
   logic [L-1:0]        level_en;

   mkey_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      entry_stage.point[0] = req_point_x;
      entry_stage.point[1] = req_point_y;
      entry_stage.point[2] = req_point_z;
      entry_stage.lo       = cfg.box_min;
      entry_stage.hi       = cfg.box_max;
      entry_stage.key      = '0;
   end

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      advance[L-1] = !st_valid[L-1] || !rsp_stall;
      for (int k = L - 2; k >= 0; k--) begin
         advance[k] = !st_valid[k] || advance[k+1];
      end
   end

   genvar k;
   generate
      for (k = 0; k < L; k++) begin : g_level
         // depths above MAX_LEVELS saturate since k never reaches them
         assign level_en[k] = (32'(cfg.tree_depth) > k);

         if (k == 0) begin : g_first
            mkey_level u_level (
               .clock     (clock),
               .reset     (reset),
               .load      (advance[k]),
               .active    (level_en[k]),
               .in_valid  (req_valid),
               .in_stage  (entry_stage),
               .out_valid (st_valid[k]),
               .out_stage (st[k])
            );
         end else begin : g_next
            mkey_level u_level (
               .clock     (clock),
               .reset     (reset),
               .load      (advance[k]),
               .active    (level_en[k]),
               .in_valid  (st_valid[k-1]),
               .in_stage  (st[k-1]),
               .out_valid (st_valid[k]),
               .out_stage (st[k])
            );
         end
      end

      if (mkey_pkg::KEY_WIDTH >= mkey_pkg::CELL_KEY_WIDTH) begin : g_key_trunc
         assign rsp_cell_key = st[L-1].key[mkey_pkg::CELL_KEY_WIDTH-1:0];
      end else begin : g_key_ext
         assign rsp_cell_key = mkey_pkg::CELL_KEY_WIDTH'(st[L-1].key);
      end
   endgenerate

   assign req_stall = !advance[0];
   assign rsp_valid = st_valid[L-1];

   // input is only held off when the whole pipe is full behind a stalled output
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&st_valid) && rsp_stall)
      else $error("req_stall with an empty pipeline slot");

   // an accepted item lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> st_valid[0])
      else $error("accepted item lost at the first stage");

   // an unstalled output with valid data always drains the last stage
   a_output_moves: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> advance[L-1])
      else $error("last stage blocked without output stall");

   // the first stage, when full and held by its successor, keeps its valid bit
   a_hold_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      st_valid[0] && !advance[0] |=> st_valid[0])
      else $error("held first stage dropped its item");

endmodule

// ----- hdl/mkey_csr.sv -----
// mkey_csr: configuration registers (bounding box and tree depth) of the
// octree cell key core. Depends on mkey_pkg.

module mkey_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [mkey_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [mkey_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output mkey_pkg::cfg_type                      cfg
);

   mkey_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < mkey_pkg::NUM_AXES; a++) begin
            cfg_ff.box_min[a] <= mkey_pkg::BOX_MIN_RESET;
            cfg_ff.box_max[a] <= mkey_pkg::BOX_MAX_RESET;
         end
         cfg_ff.tree_depth <= mkey_pkg::DEPTH_RESET;
      end else if (csr_wr_en) begin
         unique case (mkey_pkg::csr_index_type'(csr_index))
            mkey_pkg::CSR_BOX_MIN_X:  cfg_ff.box_min[0] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_BOX_MAX_X:  cfg_ff.box_max[0] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_BOX_MIN_Y:  cfg_ff.box_min[1] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_BOX_MAX_Y:  cfg_ff.box_max[1] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_BOX_MIN_Z:  cfg_ff.box_min[2] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_BOX_MAX_Z:  cfg_ff.box_max[2] <= csr_wdata[mkey_pkg::COORD_WIDTH-1:0];
            mkey_pkg::CSR_TREE_DEPTH: cfg_ff.tree_depth <= csr_wdata[mkey_pkg::DEPTH_WIDTH-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/mkey_level.sv -----
// mkey_level: one registered bisection level on all three axes; when active,
// appends one xyz triplet to the key. Depends on mkey_pkg.

module mkey_level (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                active,
   input  logic                in_valid,
   input  mkey_pkg::stage_type in_stage,
   output logic                out_valid,
   output mkey_pkg::stage_type out_stage
);

   logic                 valid_ff;
   mkey_pkg::stage_type  stage_ff;
   mkey_pkg::stage_type  stage_in;
   logic [mkey_pkg::NUM_AXES-1:0] upper;

   always_comb begin
      logic signed [mkey_pkg::COORD_WIDTH:0]   sum;
      logic signed [mkey_pkg::COORD_WIDTH-1:0] mid;
      stage_in = in_stage;
      upper    = '0;
      for (int a = 0; a < mkey_pkg::NUM_AXES; a++) begin
         // 33-bit sum, arithmetic halving floors the midpoint
         sum = $signed({in_stage.lo[a][mkey_pkg::COORD_WIDTH-1], in_stage.lo[a]})
             + $signed({in_stage.hi[a][mkey_pkg::COORD_WIDTH-1], in_stage.hi[a]});
         mid = sum[mkey_pkg::COORD_WIDTH:1];
         // ties go to the upper half
         upper[a] = ($signed(in_stage.point[a]) >= mid);
         if (upper[a]) begin
            stage_in.lo[a] = mid;
         end else begin
            stage_in.hi[a] = mid;
         end
      end
      if (active) begin
         // x is the high bit of the triplet
         stage_in.key = mkey_pkg::KEY_WIDTH'({in_stage.key, upper[0], upper[1], upper[2]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for octree_morton_key_core, the octree cell key core.
// Runs a table of directed points and then random points under random boxes and depths.
// Each key is checked against a local bisection model or its fixed row key. Depends on mkey_pkg and the core.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mkey_pkg::*;

   localparam int PIPE_LATENCY   = MAX_LEVELS;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_POINTS   = 140;
   localparam int KEY_FIFO_DEPTH = 64;

   localparam coord_type COORD_MIN = 32'h8000_0000;
   localparam coord_type COORD_MAX = 32'h7FFF_FFFF;
   localparam coord_type COORD_ONE = 32'h0001_0000;
   localparam coord_type COORD_HALF = 32'h0000_8000;
   localparam coord_type COORD_ZERO = 32'h0000_0000;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INDEX_UNUSED = 3'd7;

   localparam csr_index_type MIN_INDEX [NUM_AXES] = '{CSR_BOX_MIN_X, CSR_BOX_MIN_Y, CSR_BOX_MIN_Z};
   localparam csr_index_type MAX_INDEX [NUM_AXES] = '{CSR_BOX_MAX_X, CSR_BOX_MAX_Y, CSR_BOX_MAX_Z};

   localparam logic [CELL_KEY_WIDTH-1:0] KEY_ALL_UPPER = 30'h3FFF_FFFF;

   // one directed point, optionally preceded by a register write
   typedef struct packed {
      logic                          do_write;
      logic [CSR_IDX_WIDTH-1:0]      wr_index;
      logic [CSR_DATA_WIDTH-1:0]     wr_data;
      coord_type                     x;
      coord_type                     y;
      coord_type                     z;
      logic                          fixed;
      logic [CELL_KEY_WIDTH-1:0]     fixed_key;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 23;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1, 30'h0},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, KEY_ALL_UPPER},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 30'h0},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 30'h2492_4924},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 30'h1249_2492},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 30'h0924_9249},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_ONE, COORD_ONE, COORD_ONE, 1'b1, KEY_ALL_UPPER},
      // ties on the first midpoint
      '{1'b0, CSR_BOX_MIN_X, 32'h0, COORD_HALF, COORD_HALF - 1, COORD_HALF, 1'b0, 30'h0},
      // outside the box on two axes
      '{1'b0, CSR_BOX_MIN_X, 32'h0, 32'hFFFF_FFFF, COORD_ONE + 1, 32'h0000_4000, 1'b0, 30'h0},
      '{1'b1, CSR_TREE_DEPTH, 32'h0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 30'h0},
      '{1'b0, CSR_BOX_MIN_X, 32'h0, 32'h1234_5678, COORD_MIN, COORD_HALF, 1'b1, 30'h0},
      // depth above the level count saturates
      '{1'b1, CSR_TREE_DEPTH, 32'hF, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, KEY_ALL_UPPER},
      '{1'b1, CSR_TREE_DEPTH, 32'h1, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 30'h5},
      // unused index must leave depth at one
      '{1'b1, CSR_INDEX_UNUSED, 32'h0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 30'h7},
      '{1'b1, CSR_TREE_DEPTH, 32'hA, COORD_HALF, COORD_HALF, COORD_HALF, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MIN_X, COORD_MIN, COORD_MIN, COORD_ZERO, COORD_ZERO, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MAX_X, COORD_MAX, COORD_ZERO, COORD_HALF, COORD_ONE, 1'b0, 30'h0},
      // inverted box on y
      '{1'b1, CSR_BOX_MIN_Y, 32'h0001_86A0, 32'h0000_C350, 32'h0000_C350, COORD_ZERO,
        1'b0, 30'h0},
      '{1'b1, CSR_BOX_MAX_Y, 32'hFFFE_7960, COORD_MAX, 32'hFFFF_0000, COORD_HALF, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MIN_Z, COORD_MAX, COORD_ZERO, COORD_ZERO, COORD_MAX, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MAX_Z, COORD_MAX, COORD_MAX, COORD_ZERO, COORD_MAX, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MIN_Z, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 30'h0},
      '{1'b1, CSR_BOX_MAX_Z, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 30'h0}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   coord_type                     req_point_x;
   coord_type                     req_point_y;
   coord_type                     req_point_z;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [CELL_KEY_WIDTH-1:0]     rsp_cell_key;
   logic                          csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0]      csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata;

   // local copy of the box and depth registers
   logic signed [COORD_WIDTH-1:0] box_lo_cfg [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] box_hi_cfg [NUM_AXES];
   logic [DEPTH_WIDTH-1:0]        depth_cfg;

   // keys of accepted items in order, as a ring with running counts
   logic [CELL_KEY_WIDTH-1:0]     expected_keys [KEY_FIFO_DEPTH];
   int                            expect_wr = 0;
   int                            expect_rd = 0;
   int                            error_count = 0;
   int                            idle_cycles;
   bit                            send_burst = 1'b0;
   bit                            recv_burst = 1'b0;

   octree_morton_key_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cell_key (rsp_cell_key),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // bisect each axis at the floored midpoint, ties go upper, x is the high bit
   function automatic logic [CELL_KEY_WIDTH-1:0] cell_key_of(coord_type x, coord_type y,
                                                             coord_type z);
      logic signed [COORD_WIDTH-1:0] pt [NUM_AXES];
      logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
      logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];
      logic signed [COORD_WIDTH-1:0] mid;
      logic signed [COORD_WIDTH:0]   sum;
      logic [CELL_KEY_WIDTH-1:0]     key;
      logic [2:0]                    trip;
      int                            levels;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo[a] = box_lo_cfg[a];
         hi[a] = box_hi_cfg[a];
      end
      levels = (depth_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(depth_cfg);
      key = '0;
      for (int lvl = 0; lvl < levels; lvl++) begin
         trip = '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum = {lo[a][COORD_WIDTH-1], lo[a]} + {hi[a][COORD_WIDTH-1], hi[a]};
            mid = sum[COORD_WIDTH:1];
            trip = trip << 1;
            if (pt[a] >= mid) begin
               trip[0] = 1'b1;
               lo[a] = mid;
            end else begin
               hi[a] = mid;
            end
         end
         key = (key << 3) | CELL_KEY_WIDTH'(trip);
      end
      return key;
   endfunction

   // a coordinate near the box of one axis, or anywhere
   function automatic coord_type pick_coord(int a);
      longint l;
      longint h;
      longint t;
      longint unsigned offset;
      int mode;
      l = box_lo_cfg[a];
      h = box_hi_cfg[a];
      if (l > h) begin
         t = l;
         l = h;
         h = t;
      end
      mode = $urandom_range(0, 9);
      case (mode) inside
         0, 1: return coord_type'($urandom);
         2: return coord_type'(l);
         3: return coord_type'(h);
         4: return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
         5: return coord_type'(((l + h) >>> 1) + longint'($urandom_range(0, 2)) - 1);
         default: begin
            offset = {$urandom, $urandom};
            offset = offset % longint'(h - l + 1);
            return coord_type'(l + longint'(offset));
         end
      endcase
   endfunction

   task automatic csr_write(logic [CSR_IDX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_BOX_MIN_X:  box_lo_cfg[0] = data;
         CSR_BOX_MAX_X:  box_hi_cfg[0] = data;
         CSR_BOX_MIN_Y:  box_lo_cfg[1] = data;
         CSR_BOX_MAX_Y:  box_hi_cfg[1] = data;
         CSR_BOX_MIN_Z:  box_lo_cfg[2] = data;
         CSR_BOX_MAX_Z:  box_hi_cfg[2] = data;
         CSR_TREE_DEPTH: depth_cfg = data[DEPTH_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic send_point(coord_type x, coord_type y, coord_type z, logic use_fixed,
                             logic [CELL_KEY_WIDTH-1:0] fixed_key);
      int gap;
      if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_keys[expect_wr % KEY_FIFO_DEPTH] = use_fixed ? fixed_key : cell_key_of(x, y, z);
      expect_wr++;
   endtask

   // wait until the pipeline is empty so registers can change
   task automatic drain_items();
      req_valid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic program_phase(int phase);
      logic signed [COORD_WIDTH-1:0] lo;
      logic signed [COORD_WIDTH-1:0] hi;
      logic signed [COORD_WIDTH-1:0] t;
      logic [DEPTH_WIDTH-1:0]        depth;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo = $urandom;
         hi = $urandom;
         case ($urandom_range(0, 5))
            0: begin
               lo = COORD_MIN;
               hi = COORD_MAX;
            end
            1: if (lo > hi) begin
               t = lo;
               lo = hi;
               hi = t;
            end
            2: hi = lo + $urandom_range(1, 1000);
            3: if (lo < hi) begin
               t = lo;
               lo = hi;
               hi = t;
            end
            4: hi = lo;
            default: begin
               lo = COORD_ZERO;
               hi = COORD_ONE;
            end
         endcase
         csr_write(MIN_INDEX[a], lo);
         csr_write(MAX_INDEX[a], hi);
      end
      case (phase)
         0: depth = 4'd10;
         1: depth = 4'd0;
         2: depth = 4'd15;
         3: depth = 4'd1;
         default: depth = DEPTH_WIDTH'($urandom_range(0, 15));
      endcase
      csr_write(CSR_TREE_DEPTH, CSR_DATA_WIDTH'(depth));
      if ($urandom_range(0, 1) != 0) csr_write(CSR_INDEX_UNUSED, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // result side: random stalls, check each key in order
   initial begin
      logic [CELL_KEY_WIDTH-1:0] want;
      int                        stall_cycles;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
         stall_cycles = recv_burst ? 0 : $urandom_range(0, 6);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expect_wr == expect_rd) begin
            $error("cell_key: result with no item waiting, actual %h", rsp_cell_key);
            error_count++;
         end else begin
            want = expected_keys[expect_rd % KEY_FIFO_DEPTH];
            expect_rd++;
            if (rsp_cell_key !== want) begin
               $error("cell_key: expected %h, actual %h", want, rsp_cell_key);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   initial begin
      idle_cycles = 0;
      do @(posedge clock); while (reset !== 1'b0);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      directed_row_type row;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      rsp_stall   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         box_lo_cfg[a] = BOX_MIN_RESET;
         box_hi_cfg[a] = BOX_MAX_RESET;
      end
      depth_cfg = DEPTH_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.do_write) begin
            drain_items();
            csr_write(row.wr_index, row.wr_data);
            csr_wr_en <= 1'b0;
         end
         send_point(row.x, row.y, row.z, row.fixed, row.fixed_key);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_items();
         program_phase(phase);
         for (int i = 0; i < PHASE_POINTS; i++) begin
            send_point(pick_coord(0), pick_coord(1), pick_coord(2), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
